/* rtl/core/heap_build_engine_core_assert.svh */
// ----------------------------------------------------------------------------
// Heap build engine assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEAP_BUILD_ENGINE_CORE_ASSERT_SVH
`define HEAP_BUILD_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBE_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/hbe_pkg.sv */
// ----------------------------------------------------------------------------
// Heap build engine package
// Shared widths, default capacity and the compare request type.
// ----------------------------------------------------------------------------
package hbe_pkg;

    localparam int HBE_DEPTH = 64;
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Request to the shared compare unit
    typedef struct packed {
        logic signed [DATA_W-1:0] cand;
        logic signed [DATA_W-1:0] incumbent;
        logic                     min_mode;
    } cmp_req_t;

endpackage

/* rtl/core/hbe_ram.sv */
// ----------------------------------------------------------------------------
// Heap build engine RAM
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/hbe_cmp.sv */
// ----------------------------------------------------------------------------
// Heap build engine compare unit
// Decides whether a candidate ranks strictly above the current pick.
// ----------------------------------------------------------------------------
module hbe_cmp (
    input  hbe_pkg::cmp_req_t req,
    output logic              above
);

    import hbe_pkg::*;

    logic gt;
    logic lt;

    assign gt    = $signed(req.cand) > $signed(req.incumbent);
    assign lt    = $signed(req.cand) < $signed(req.incumbent);
    // strict in both modes: equal values never move
    assign above = req.min_mode ? lt : gt;

endmodule

/* rtl/core/heap_build_engine_core.sv */
// ----------------------------------------------------------------------------
// Heap build engine core
// Loads a set of signed values, heapifies it bottom up with one shared
// compare unit over a single RAM, then streams the heap out in index order.
// ----------------------------------------------------------------------------
//  port group | dir | payload                                  | end marker
//  s_*        | in  | tdata[31:0] value                        | tlast = last
//  m_*        | out | tdata[31:0] value_res, tuser[0] overflow | tlast = last_res
//  cfg_*      | in  | cfg_wdata = heap_order (0 max, 1 min)    | -
//
// Load writes each item up to DEPTH into the RAM. After the last item the build
// runs from node n/2-1 down to 0: fetch the node (ST_PLD), read the left child
// (ST_SIFT), compare it and read any right child (ST_CL), compare that (ST_CR),
// then swap (ST_DEC, ST_WR2) or stop, as the one RAM read and write port allow;
// ST_NEXT at node 0 ends the build; m_tready low holds the emission sequencer.
// s_tready is low from the last item until the final result is registered.
// No clearing pass after reset; rst_n clears the control state at once.
// ----------------------------------------------------------------------------
`include "heap_build_engine_core_assert.svh"

module heap_build_engine_core #(
    parameter int DEPTH = hbe_pkg::HBE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // cfg: heap_order
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    // s_tdata: [31:0] value
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hbe_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tlast,
    // m_tdata: [31:0] value_res
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [hbe_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    // m_tuser: [0] overflow
    output logic                       m_tuser
);

    import hbe_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CHW = AW + 2;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_BINIT = 4'd1;
    localparam logic [3:0] ST_PLD   = 4'd2;
    localparam logic [3:0] ST_SIFT  = 4'd3;
    localparam logic [3:0] ST_CL    = 4'd4;
    localparam logic [3:0] ST_CR    = 4'd5;
    localparam logic [3:0] ST_DEC   = 4'd6;
    localparam logic [3:0] ST_WR2   = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_ERD   = 4'd9;
    localparam logic [3:0] ST_EOUT  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          heap_order_reg, heap_order_next;
    logic          order_reg, order_next;
    logic [AW-1:0] build_reg, build_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [AW-1:0] eidx_reg, eidx_next;
    logic          m_valid_reg, m_valid_next;

    data_t         pval_reg, pval_next;
    data_t         best_val_reg, best_val_next;
    data_t         m_data_reg;
    logic          m_last_reg;
    logic          m_ovf_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    data_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    data_t         rd_val;

    cmp_req_t      cmp_req;
    logic          cmp_above;

    logic [CHW-1:0] left_idx;
    logic [CHW-1:0] right_idx;
    logic [CHW-1:0] count_ext;
    logic [AW-1:0]  half_m1;
    logic           s_fire;
    logic           out_free;
    logic           out_load;
    logic           last_hit;

    hbe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val = data_t'(ram_rdata);

    assign cmp_req.cand      = rd_val;
    assign cmp_req.incumbent = best_val_reg;
    assign cmp_req.min_mode  = order_reg;

    hbe_cmp u_cmp (
        .req   (cmp_req),
        .above (cmp_above)
    );

    assign left_idx  = {1'b0, node_reg, 1'b1};
    assign right_idx = left_idx + CHW'(1);
    assign count_ext = CHW'(count_reg);
    assign half_m1   = AW'((count_reg >> 1) - CW'(1));
    assign last_hit  = (CW'(eidx_reg) + CW'(1)) == count_reg;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign heap_order_next = cfg_we ? cfg_wdata : heap_order_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        order_next    = order_reg;
        build_next    = build_reg;
        node_next     = node_reg;
        best_idx_next = best_idx_reg;
        eidx_next     = eidx_reg;
        pval_next     = pval_reg;
        best_val_next = best_val_reg;
        ram_we        = 1'b0;
        ram_waddr     = node_reg;
        ram_wdata     = best_val_reg;
        ram_raddr     = eidx_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_fire)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = data_t'(s_tdata);
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        order_next = heap_order_reg;
                        state_next = ST_BINIT;
                    end
                end
            end
            ST_BINIT:
            begin
                if (count_reg < CW'(2))
                begin
                    eidx_next  = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    build_next = half_m1;
                    node_next  = half_m1;
                    ram_raddr  = half_m1;
                    state_next = ST_PLD;
                end
            end
            ST_PLD:
            begin
                pval_next  = rd_val;
                state_next = ST_SIFT;
            end
            ST_SIFT:
            begin
                if (left_idx < count_ext)
                begin
                    ram_raddr     = left_idx[AW-1:0];
                    best_val_next = pval_reg;
                    best_idx_next = node_reg;
                    state_next    = ST_CL;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_CL:
            begin
                if (cmp_above)
                begin
                    best_val_next = rd_val;
                    best_idx_next = left_idx[AW-1:0];
                end
                if (right_idx < count_ext)
                begin
                    ram_raddr  = right_idx[AW-1:0];
                    state_next = ST_CR;
                end
                else
                begin
                    state_next = ST_DEC;
                end
            end
            ST_CR:
            begin
                if (cmp_above)
                begin
                    best_val_next = rd_val;
                    best_idx_next = right_idx[AW-1:0];
                end
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (best_idx_reg == node_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    // move the winning child up
                    ram_we     = 1'b1;
                    ram_waddr  = node_reg;
                    ram_wdata  = best_val_reg;
                    state_next = ST_WR2;
                end
            end
            ST_WR2:
            begin
                // drop the sifted value into the child slot and follow it
                ram_we     = 1'b1;
                ram_waddr  = best_idx_reg;
                ram_wdata  = pval_reg;
                node_next  = best_idx_reg;
                state_next = ST_SIFT;
            end
            ST_NEXT:
            begin
                if (build_reg == '0)
                begin
                    eidx_next  = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    build_next = build_reg - AW'(1);
                    node_next  = build_reg - AW'(1);
                    ram_raddr  = build_reg - AW'(1);
                    state_next = ST_PLD;
                end
            end
            ST_ERD:
            begin
                ram_raddr  = eidx_reg;
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                // hold the read address while the output register is full
                ram_raddr = eidx_reg;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (last_hit)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        eidx_next = eidx_reg + AW'(1);
                        ram_raddr = eidx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            heap_order_reg <= 1'b0;
            order_reg      <= 1'b0;
            build_reg      <= '0;
            node_reg       <= '0;
            best_idx_reg   <= '0;
            eidx_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            heap_order_reg <= heap_order_next;
            order_reg      <= order_next;
            build_reg      <= build_next;
            node_reg       <= node_next;
            best_idx_reg   <= best_idx_next;
            eidx_reg       <= eidx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pval_reg     <= pval_next;
        best_val_reg <= best_val_next;
        if (out_load)
        begin
            m_data_reg <= rd_val;
            m_last_reg <= last_hit;
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

    `HBE_ASSERT(a_count_cap, clk, rst_n, count_reg <= CW'(DEPTH), "element count beyond capacity")
    `HBE_ASSERT(a_ovf_set, clk, rst_n, (s_fire && count_reg == CW'(DEPTH)) |=> ovf_reg, "dropped item did not set overflow")
    `HBE_ASSERT(a_swap_child, clk, rst_n, (state_reg == ST_WR2) |-> (best_idx_reg != node_reg), "swap with the node itself")
    `HBE_ASSERT(a_left_in_set, clk, rst_n, (state_reg == ST_CL) |-> (left_idx < count_ext), "left child read past the set")
    `HBE_ASSERT(a_set_cleared, clk, rst_n, (state_reg == ST_LOAD && $past(state_reg) == ST_EOUT) |-> (count_reg == '0 && !ovf_reg), "set not cleared after emission")

endmodule

/* tb/tb_heap_build_engine_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap build engine core testbench
// Streams sets of signed values into the core, rebuilds each set in a
// shadow array with the same bottom-up sift-down, and checks every streamed
// heap word, end marker and overflow flag. It covers both heap orders, full
// and overflowing sets, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_heap_build_engine_core;

    import hbe_pkg::*;

    localparam int   DEPTH       = HBE_DEPTH;
    localparam int   CYCLE_LIMIT = 500000;
    localparam int   LONG_HOLD   = 400;
    localparam bit   ORDER_MAX   = 1'b0;
    localparam bit   ORDER_MIN   = 1'b1;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } load_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } heap_word_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // shadow of the core state
    data_t heap_img [DEPTH];
    int    img_count = 0;
    bit    img_ovf   = 1'b0;
    bit    min_order = ORDER_MAX;

    load_item_t pending_items [$];
    heap_word_t heap_due [$];

    bit idle_on       = 1'b1;
    bit long_hold_arm = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int errors        = 0;
    int sets_total    = 0;
    int items_total   = 0;
    int dropped_total = 0;
    int words_checked = 0;

    heap_build_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // --------------------------------------------------------------------
    // Shadow heap build
    // --------------------------------------------------------------------
    function automatic bit ranks_above(data_t a, data_t b);
        return min_order ? (a < b) : (a > b);
    endfunction

    function automatic void sift_node(int node);
        int    pick;
        int    lc;
        data_t tmp;
        bit    moving;
        moving = 1'b1;
        while (moving)
        begin
            pick = node;
            lc   = 2 * node + 1;
            if (lc < img_count && ranks_above(heap_img[lc], heap_img[pick]))
                pick = lc;
            if (lc + 1 < img_count && ranks_above(heap_img[lc + 1], heap_img[pick]))
                pick = lc + 1;
            if (pick == node)
                moving = 1'b0;
            else
            begin
                tmp            = heap_img[node];
                heap_img[node] = heap_img[pick];
                heap_img[pick] = tmp;
                node           = pick;
            end
        end
    endfunction

    // Load one value; on the end marker heapify and queue the whole array.
    function automatic void load_and_heapify(logic [DATA_W-1:0] v, logic lst);
        heap_word_t w;
        items_total++;
        if (img_count < DEPTH)
        begin
            heap_img[img_count] = v;
            img_count++;
        end
        else
        begin
            img_ovf = 1'b1;
            dropped_total++;
        end
        if (lst)
        begin
            for (int k = img_count / 2; k > 0; k--)
                sift_node(k - 1);
            for (int k = 0; k < img_count; k++)
            begin
                w.value = heap_img[k];
                w.last  = (k == img_count - 1);
                w.ovf   = img_ovf;
                heap_due.insert(heap_due.size(), w);
            end
            img_count = 0;
            img_ovf   = 1'b0;
            sets_total++;
        end
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            5, 6:    v = 32'($urandom_range(0, 16)) - 32'd8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // --------------------------------------------------------------------
    // Input driver
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin
        load_item_t nxt;
        if (s_tvalid && s_tready)
            load_and_heapify(s_tdata, s_tlast);
        if (!s_tvalid || s_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.value;
                s_tlast  <= nxt.last;
                send_gap <= pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // --------------------------------------------------------------------
    // Output monitor and ready driver
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_word_t w;
        if (m_tvalid && m_tready)
        begin
            words_checked++;
            if (heap_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: value=%0d last=%b ovf=%b",
                             $signed(m_tdata), m_tlast, m_tuser);
            end
            else
            begin
                w = heap_due.pop_front();
                if (m_tdata !== w.value || m_tlast !== w.last || m_tuser !== w.ovf)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
                                 $signed(w.value), w.last, w.ovf,
                                 $signed(m_tdata), m_tlast, m_tuser);
                end
            end
        end

        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (long_hold_arm && !long_hold_done && m_tvalid)
        begin
            // hold off long enough for the core to back up its input
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            m_tready       <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            hold_left <= pick_gap();
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still due", cycle_count,
                     heap_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    task automatic push_value(logic [DATA_W-1:0] v, logic lst);
        load_item_t it;
        it.value = v;
        it.last  = lst;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_random_set(int n);
        for (int i = 0; i < n; i++)
            push_value(pick_value(), i == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || heap_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_heap_order(bit order);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= order;
        min_order = order;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int n;
        int phase_items;
        bit paused;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // max heap from the reset value of the order register
        push_value(VAL_MAX, 1'b1);
        push_value(VAL_MIN, 1'b0);  push_value(VAL_MAX, 1'b1);
        push_value('1, 1'b0);       push_value('0, 1'b0);
        push_value(VAL_MIN, 1'b0);  push_value(32'd1, 1'b0);
        push_value(VAL_MAX, 1'b0);  push_value('1, 1'b0);
        push_value(32'd7, 1'b1);
        // equal values stay put
        push_value(32'd5, 1'b0);    push_value(32'd5, 1'b0);
        push_value(32'd5, 1'b1);
        wait_drained();

        write_heap_order(ORDER_MIN);
        push_value(VAL_MAX, 1'b0);  push_value(VAL_MIN, 1'b1);
        push_value(32'd3, 1'b0);    push_value(32'd3, 1'b0);
        push_value(-32'sd7, 1'b0);  push_value(32'd3, 1'b0);
        push_value(VAL_MIN, 1'b0);  push_value(VAL_MAX, 1'b1);
        push_value('0, 1'b1);

        paused = 1'b0;
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            write_heap_order(p == 0 ? ORDER_MAX :
                             p == 1 ? ORDER_MIN : bit'($urandom_range(0, 1)));
            idle_on <= (p != 2);
            if (p == 1)
                long_hold_arm <= 1'b1;
            // exactly full, then one that overflows and drops the item carrying the end marker
            if (p == 3)
                push_random_set(DEPTH);
            if (p == 4)
                push_random_set(DEPTH + 2);
            phase_items = 0;
            while (phase_items < 4)
            begin
                n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                : $urandom_range(9, 20);
                push_random_set(n);
                phase_items += n;
                if (p == 2 && !paused && phase_items >= 2)
                begin
                    // let every pending result drain before sending more
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Ran %0d sets of %0d items (%0d dropped past capacity) in max and min order.",
                 sets_total, items_total, dropped_total);
        $display("Checked %0d heap items, %0d failures.", words_checked, errors);
        if (errors == 0 && heap_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hbe_pkg.sv
rtl/core/hbe_ram.sv
rtl/core/hbe_cmp.sv
rtl/core/heap_build_engine_core.sv
tb/tb_heap_build_engine_core.sv
